// ===== design/cndf_pkg.sv =====
// Shared types and constants for the calculator number display formatter.
// Used by cndf_ctrl, cndf_datapath and calc_number_display_format.
package cndf_pkg;

   localparam int MANT_W      = 45;
   localparam int EXP_W       = 8;
   localparam int MAG_W       = 44;
   localparam int NUM_DIGITS  = 13;
   localparam int M_DIGITS    = 10;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 8;
   localparam int CHAR_W      = 6;
   localparam int FIX_W       = 4;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CNT_W       = 6;

   localparam logic [MAG_W-1:0] MANT_MAX = 44'd9999999999999;

   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_DECIMALS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_MODE   = 1'd1;

   localparam logic [MODE_W-1:0] MODE_FLOAT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENG   = 2'd2;
   localparam logic [FIX_W-1:0]  FIX_FREE   = 4'd9;

   localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_QUERY = 6'd63;

   typedef logic [3:0] digit_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_CONV, S_SETUP, S_BUILD,
      S_ROUND, S_CHECK, S_TRIM, S_FINAL, S_EMIT
   } ctl_state_type;

   typedef enum logic [3:0] {
      P_SIGN, P_LEADPT, P_DIGIT, P_POINT, P_EXPS,
      P_EXPT, P_EXPO, P_ERRS, P_ERRQ, P_DONE
   } emit_phase_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic conv;
      logic setup;
      logic build;
      logic round;
      logic retry;
      logic trim;
      logic fin;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic round_done;
      logic need_retry;
      logic trim_more;
      logic emit_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== design/cndf_ctrl.sv =====
// Sequencer for the display formatter: steps the datapath through
// conversion, rounding, trimming and character output. Uses cndf_pkg.
module cndf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cndf_pkg::dp_stat_type  stat,
   output cndf_pkg::dp_cmd_type   cmd
);

   cndf_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cndf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cndf_pkg::S_IDLE:  if (req_tvalid) state_in = cndf_pkg::S_PREP;
         cndf_pkg::S_PREP:  state_in = cndf_pkg::S_CONV;
         cndf_pkg::S_CONV:  if (stat.conv_done) state_in = cndf_pkg::S_SETUP;
         cndf_pkg::S_SETUP: state_in = cndf_pkg::S_BUILD;
         cndf_pkg::S_BUILD: state_in = cndf_pkg::S_ROUND;
         cndf_pkg::S_ROUND: if (stat.round_done) state_in = cndf_pkg::S_CHECK;
         cndf_pkg::S_CHECK: begin
            state_in = stat.need_retry ? cndf_pkg::S_SETUP : cndf_pkg::S_TRIM;
         end
         cndf_pkg::S_TRIM:  if (!stat.trim_more) state_in = cndf_pkg::S_FINAL;
         cndf_pkg::S_FINAL: state_in = cndf_pkg::S_EMIT;
         cndf_pkg::S_EMIT:  if (stat.out_free && stat.emit_last) state_in = cndf_pkg::S_IDLE;
         default:           state_in = cndf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cndf_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         cndf_pkg::S_PREP:  cmd.prep  = 1'b1;
         cndf_pkg::S_CONV:  cmd.conv  = 1'b1;
         cndf_pkg::S_SETUP: cmd.setup = 1'b1;
         cndf_pkg::S_BUILD: cmd.build = 1'b1;
         cndf_pkg::S_ROUND: cmd.round = 1'b1;
         cndf_pkg::S_CHECK: cmd.retry = stat.need_retry;
         cndf_pkg::S_TRIM:  cmd.trim  = stat.trim_more;
         cndf_pkg::S_FINAL: cmd.fin   = 1'b1;
         cndf_pkg::S_EMIT:  cmd.emit  = stat.out_free;
         default: ;
      endcase
   end

endmodule

// ===== design/cndf_datapath.sv =====
// Datapath of the display formatter: settings, BCD conversion, rounding,
// trimming and the character emitter with its output register. Uses cndf_pkg.
module cndf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cndf_pkg::dp_cmd_type                 cmd,
   output cndf_pkg::dp_stat_type                stat,
   input  logic [cndf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [cndf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cndf_pkg::FIX_W-1:0]           csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cndf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);

   logic [cndf_pkg::FIX_W-1:0]  fix_ff;
   logic [cndf_pkg::MODE_W-1:0] mode_ff;

   logic [cndf_pkg::MANT_W-1:0]  raw_ff, raw_in;
   logic signed [7:0]            exp_ff, exp_in;
   logic                         neg_ff, neg_in;
   logic [cndf_pkg::MAG_W-1:0]   bin_ff, bin_in;
   cndf_pkg::digit_type [cndf_pkg::NUM_DIGITS-1:0] bcd_ff, bcd_in;
   logic [cndf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         isx_ff, isx_in;
   logic [3:0]                   ilen_ff, ilen_in, flen_ff, flen_in, mlen_ff, mlen_in;
   logic signed [7:0]            keep_ff, keep_in, dexp_ff, dexp_in;
   cndf_pkg::digit_type [cndf_pkg::M_DIGITS-1:0] md_ff, md_in;
   logic                         carry_ff, carry_in, hit_ff, hit_in;
   logic                         retried_ff, retried_in, err_ff, err_in;
   cndf_pkg::emit_phase_type     phase_ff, phase_in;
   logic [3:0]                   j_ff, j_in;
   logic                         rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [cndf_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;

   // request capture
   logic signed [7:0]            e_raw;
   logic [cndf_pkg::MANT_W-1:0]  mag_full;
   // conversion
   cndf_pkg::digit_type [cndf_pkg::NUM_DIGITS-1:0] adj;
   // setup
   logic                         big, tiny, zap, isx, fix_free;
   logic signed [7:0]            ew, ew1, s_keep, s_dexp;
   logic [7:0]                   eoff, t3;
   logic [15:0]                  qprod;
   logic [6:0]                   qq;
   logic [1:0]                   rem;
   logic [3:0]                   s_ilen, s_mlen0, s_flen0, s_flen, s_mlen;
   // build and round
   logic [3:0]                   kk;
   logic                         kpos;
   logic [4:0]                   src, rsum;
   cndf_pkg::digit_type [cndf_pkg::M_DIGITS-1:0] b_md;
   logic                         b_carry, rwrap;
   logic [3:0]                   rdig;
   // final
   logic                         mnz, f_zero, f_err, f_neg;
   logic [3:0]                   f_il, f_ilen, f_min7;
   // emit
   logic [3:0]                   total, didx, jn, tens, ones;
   logic signed [7:0]            negd;
   logic [6:0]                   aexp;
   logic [14:0]                  tprod;
   cndf_pkg::emit_phase_type     tail_ph, next_ph;
   logic [3:0]                   next_j;
   logic [cndf_pkg::CHAR_W-1:0]  cur_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff  <= cndf_pkg::FIX_FREE;
         mode_ff <= cndf_pkg::MODE_FLOAT;
      end else if (csr_we) begin
         unique case (csr_index)
            cndf_pkg::CSR_FIXED_DECIMALS: fix_ff  <= csr_wdata;
            cndf_pkg::CSR_DISPLAY_MODE:   mode_ff <= csr_wdata[cndf_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // setup: format geometry from exponent and settings
   always_comb begin
      fix_free = (fix_ff == cndf_pkg::FIX_FREE);
      big   = (exp_ff >= 8'sd10);
      tiny  = (exp_ff <= -8'sd12) || ((exp_ff == -8'sd11) && (bcd_ff[0] < 4'd5));
      zap   = tiny && !fix_free && (mode_ff == cndf_pkg::MODE_FLOAT);
      ew    = zap ? 8'sd0 : exp_ff;
      isx   = !zap && ((mode_ff != cndf_pkg::MODE_FLOAT) || big || (tiny && fix_free));
      eoff  = ew[7:0] + 8'd102;
      qprod = 16'(eoff) * 16'd171;
      qq    = qprod[15:9];
      t3    = 8'({qq, 1'b0}) + 8'(qq);
      rem   = 2'(eoff - t3);
      ew1   = ew + 8'sd1;
      if (isx) begin
         s_mlen0 = 4'd8;
         if (mode_ff == cndf_pkg::MODE_ENG) begin
            s_ilen = 4'd1 + 4'(rem);
            s_dexp = ew - $signed({6'b0, rem});
         end else begin
            s_ilen = 4'd1;
            s_dexp = ew;
         end
      end else begin
         s_mlen0 = 4'd10;
         s_ilen  = (ew1 > 8'sd0) ? ew1[3:0] : 4'd0;
         s_dexp  = ew;
      end
      s_flen0 = s_mlen0 - s_ilen;
      s_flen  = (!fix_free && (s_flen0 > fix_ff)) ? fix_ff : s_flen0;
      s_mlen  = s_ilen + s_flen;
      if (!isx && (ew < 8'sd0)) begin
         s_keep = $signed({4'b0, s_flen}) + ew + 8'sd1;
      end else begin
         s_keep = $signed({4'b0, s_mlen});
      end
   end

   // build: right-align kept digits, pick rounding digit
   always_comb begin
      kk   = keep_ff[3:0];
      kpos = !keep_ff[7];
      src  = '0;
      for (int p = 0; p < cndf_pkg::M_DIGITS; p++) begin
         src = 5'(p) + {1'b0, kk};
         if (kpos && (src >= 5'd10)) begin
            b_md[p] = bcd_ff[4'(src - 5'd10)];
         end else begin
            b_md[p] = 4'd0;
         end
      end
      b_carry = kpos && (bcd_ff[kk] >= 4'd5);
      rsum    = 5'(md_ff[cndf_pkg::M_DIGITS-1]) + 5'(carry_ff);
      rwrap   = (rsum == 5'd10);
      rdig    = rwrap ? 4'd0 : rsum[3:0];
   end

   // final adjustment and emitter
   always_comb begin
      mnz    = |md_ff;
      f_il   = ((ilen_ff == 4'd0) && (mlen_ff < 4'd10)) ? 4'd1 : ilen_ff;
      f_min7 = (fix_ff < 4'd7) ? fix_ff : 4'd7;
      f_zero = !mnz;
      f_err  = mnz && ((dexp_ff == 8'sd100) || ((dexp_ff == 8'sd99) && (f_il > 4'd1)));
      f_neg  = neg_ff && !f_zero;
      f_ilen = (f_zero || f_err) ? 4'd1 : f_il;

      total = ilen_ff + flen_ff;
      didx  = 4'd10 - total + j_ff;
      jn    = j_ff + 4'd1;
      negd  = -dexp_ff;
      aexp  = dexp_ff[7] ? negd[6:0] : dexp_ff[6:0];
      tprod = 15'(aexp) * 15'd205;
      tens  = tprod[14:11];
      ones  = 4'(aexp - 7'({tens, 3'b0}) - 7'({tens, 1'b0}));
      tail_ph = isx_ff ? cndf_pkg::P_EXPS : (err_ff ? cndf_pkg::P_ERRS : cndf_pkg::P_DONE);
      next_j  = j_ff;
      unique case (phase_ff)
         cndf_pkg::P_SIGN: begin
            cur_char = cndf_pkg::CH_MINUS;
            next_ph  = (ilen_ff == 4'd0) ? cndf_pkg::P_LEADPT : cndf_pkg::P_DIGIT;
         end
         cndf_pkg::P_LEADPT: begin
            cur_char = cndf_pkg::CH_POINT;
            next_ph  = cndf_pkg::P_DIGIT;
         end
         cndf_pkg::P_DIGIT: begin
            cur_char = cndf_pkg::CH_ZERO + 6'(md_ff[didx]);
            if (jn == ilen_ff) begin
               next_ph = cndf_pkg::P_POINT;
            end else if (jn < total) begin
               next_ph = cndf_pkg::P_DIGIT;
               next_j  = jn;
            end else begin
               next_ph = tail_ph;
            end
         end
         cndf_pkg::P_POINT: begin
            cur_char = cndf_pkg::CH_POINT;
            if (jn < total) begin
               next_ph = cndf_pkg::P_DIGIT;
               next_j  = jn;
            end else begin
               next_ph = tail_ph;
            end
         end
         cndf_pkg::P_EXPS: begin
            cur_char = dexp_ff[7] ? cndf_pkg::CH_MINUS : cndf_pkg::CH_SPACE;
            next_ph  = cndf_pkg::P_EXPT;
         end
         cndf_pkg::P_EXPT: begin
            cur_char = cndf_pkg::CH_ZERO + 6'(tens);
            next_ph  = cndf_pkg::P_EXPO;
         end
         cndf_pkg::P_EXPO: begin
            cur_char = cndf_pkg::CH_ZERO + 6'(ones);
            next_ph  = err_ff ? cndf_pkg::P_ERRS : cndf_pkg::P_DONE;
         end
         cndf_pkg::P_ERRS: begin
            cur_char = cndf_pkg::CH_SPACE;
            next_ph  = cndf_pkg::P_ERRQ;
         end
         cndf_pkg::P_ERRQ: begin
            cur_char = cndf_pkg::CH_QUERY;
            next_ph  = cndf_pkg::P_DONE;
         end
         default: begin
            cur_char = cndf_pkg::CH_SPACE;
            next_ph  = cndf_pkg::P_DONE;
         end
      endcase
   end

   // next register values
   always_comb begin
      raw_in = raw_ff;   exp_in = exp_ff;     neg_in = neg_ff;     bin_in = bin_ff;
      bcd_in = bcd_ff;   cnt_in = cnt_ff;     isx_in = isx_ff;     ilen_in = ilen_ff;
      flen_in = flen_ff; mlen_in = mlen_ff;   keep_in = keep_ff;   dexp_in = dexp_ff;
      md_in = md_ff;     carry_in = carry_ff; hit_in = hit_ff;     retried_in = retried_ff;
      err_in = err_ff;   phase_in = phase_ff; j_in = j_ff;
      rsp_char_in = rsp_char_ff; rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      e_raw    = $signed(req_tdata[52:45]);
      mag_full = raw_ff[cndf_pkg::MANT_W-1] ? (~raw_ff + 45'd1) : raw_ff;
      for (int i = 0; i < cndf_pkg::NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end

      if (cmd.load) begin
         raw_in     = req_tdata[cndf_pkg::MANT_W-1:0];
         retried_in = 1'b0;
         if (e_raw > 8'sd99) begin
            exp_in = 8'sd99;
         end else if (e_raw < -8'sd99) begin
            exp_in = -8'sd99;
         end else begin
            exp_in = e_raw;
         end
      end
      if (cmd.prep) begin
         neg_in = raw_ff[cndf_pkg::MANT_W-1];
         bin_in = (mag_full > {1'b0, cndf_pkg::MANT_MAX}) ? cndf_pkg::MANT_MAX
                                                          : mag_full[cndf_pkg::MAG_W-1:0];
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.conv) begin
         for (int i = 0; i < cndf_pkg::NUM_DIGITS - 1; i++) begin
            bcd_in[i] = {adj[i][2:0], adj[i+1][3]};
         end
         bcd_in[cndf_pkg::NUM_DIGITS-1] = {adj[cndf_pkg::NUM_DIGITS-1][2:0],
                                           bin_ff[cndf_pkg::MAG_W-1]};
         bin_in = {bin_ff[cndf_pkg::MAG_W-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
      end
      if (cmd.setup) begin
         if (zap) begin
            exp_in = 8'sd0;
            bcd_in = '0;
            neg_in = 1'b0;
         end
         isx_in  = isx;
         ilen_in = s_ilen;
         flen_in = s_flen;
         mlen_in = s_mlen;
         keep_in = s_keep;
         dexp_in = s_dexp;
      end
      if (cmd.build) begin
         md_in    = b_md;
         carry_in = b_carry;
         cnt_in   = '0;
         hit_in   = 1'b0;
      end
      if (cmd.round) begin
         if (keep_ff == $signed({2'b0, cnt_ff})) hit_in = carry_ff;
         if (cnt_ff < 6'd10) begin
            for (int p = 1; p < cndf_pkg::M_DIGITS; p++) begin
               md_in[p] = md_ff[p-1];
            end
            md_in[0] = rdig;
            carry_in = rwrap;
            cnt_in   = cnt_ff + 6'd1;
         end
      end
      if (cmd.retry) begin
         bcd_in     = '0;
         bcd_in[0]  = 4'd1;
         exp_in     = exp_ff + 8'sd1;
         retried_in = 1'b1;
      end
      if (cmd.trim) begin
         for (int p = 1; p < cndf_pkg::M_DIGITS; p++) begin
            md_in[p] = md_ff[p-1];
         end
         md_in[0] = 4'd0;
         flen_in  = flen_ff - 4'd1;
         mlen_in  = mlen_ff - 4'd1;
      end
      if (cmd.fin) begin
         neg_in  = f_neg;
         ilen_in = f_ilen;
         err_in  = f_err;
         j_in    = 4'd0;
         if (f_zero) begin
            flen_in = (fix_ff < cndf_pkg::FIX_FREE) ? (isx_ff ? f_min7 : fix_ff) : 4'd0;
            dexp_in = 8'sd0;
         end else if (f_err) begin
            flen_in = f_min7;
            dexp_in = 8'sd99;
            for (int p = 0; p < cndf_pkg::M_DIGITS; p++) begin
               md_in[p] = 4'd9;
            end
         end
         if (f_neg) begin
            phase_in = cndf_pkg::P_SIGN;
         end else if (f_ilen == 4'd0) begin
            phase_in = cndf_pkg::P_LEADPT;
         end else begin
            phase_in = cndf_pkg::P_DIGIT;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = cur_char;
         rsp_last_in  = (next_ph == cndf_pkg::P_DONE);
         phase_in     = next_ph;
         j_in         = next_j;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         retried_ff   <= 1'b0;
         phase_ff     <= cndf_pkg::P_DONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         retried_ff   <= retried_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;   exp_ff <= exp_in;     neg_ff <= neg_in;     bin_ff <= bin_in;
      bcd_ff <= bcd_in;   cnt_ff <= cnt_in;     isx_ff <= isx_in;     ilen_ff <= ilen_in;
      flen_ff <= flen_in; mlen_ff <= mlen_in;   keep_ff <= keep_in;   dexp_ff <= dexp_in;
      md_ff <= md_in;     carry_ff <= carry_in; hit_ff <= hit_in;     err_ff <= err_in;
      j_ff <= j_in;       rsp_char_ff <= rsp_char_in; rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      stat.conv_done  = (cnt_ff == 6'(cndf_pkg::MAG_W - 1));
      stat.round_done = (cnt_ff == 6'd10);
      stat.need_retry = hit_ff && (keep_ff == $signed({4'b0, mlen_ff})) && !retried_ff;
      stat.trim_more  = fix_free && mnz && (md_ff[cndf_pkg::M_DIGITS-1] == 4'd0)
                        && (flen_ff != 4'd0);
      stat.emit_last  = (next_ph == cndf_pkg::P_DONE);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/calc_number_display_format.sv =====
// Top level of the calculator number display formatter.
// Joins cndf_ctrl and cndf_datapath; types from cndf_pkg.
//
//   channel  direction  contents
//   req      in         one number: mantissa and exponent
//   rsp      out        display text, one character per result, 2 to 15 per request
//   csr      in         register writes: fixed decimals, display mode
//
// A request passes through capture, bit-serial BCD conversion, setup and
// digit-serial rounding (repeated once on a rounding carry), trimming, a final
// step, then emits one character per cycle while the output is not held;
// conversion sets most of its time.
// Synchronous reset returns the sequencer to idle, fixed decimals to 9, mode to 0.
// req_tready is high only while idle; a held rsp character stalls the emitter.
module calc_number_display_format (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [44:0] mantissa_value, [52:45] exponent_value, [55:53] zero
   input  logic [cndf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] text_char, [7:6] zero
   output logic [cndf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [cndf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cndf_pkg::FIX_W-1:0]          csr_wdata
);

   cndf_pkg::dp_cmd_type  cmd;
   cndf_pkg::dp_stat_type stat;

   cndf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cndf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
